### rtl/hsvc_pkg.sv
`default_nettype none

package hsvc_pkg;

  // pixel in, result out
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } hsvc_in_t;

  typedef struct packed {
    logic [7:0] hue_half;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsvc_out_t;

  // quotient widths: saturation <= 255, hue sector offset <= 30
  localparam int unsigned SAT_QW          = 8;
  localparam int unsigned HUE_QW          = 5;
  localparam int unsigned STEPS_PER_STAGE = 2;
  localparam int unsigned DIV_STAGES      = (SAT_QW + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  // hue bases in half degrees
  localparam logic [7:0] HUE_HALF_RED      = 8'd0;
  localparam logic [7:0] HUE_HALF_RED_WRAP = 8'd180;
  localparam logic [7:0] HUE_HALF_GREEN    = 8'd60;
  localparam logic [7:0] HUE_HALF_BLUE     = 8'd120;
  localparam logic [7:0] HUE_HALF_MAX      = 8'd179;

  // divider state carried down the pipe
  typedef struct packed {
    logic [7:0]        mx;
    logic [7:0]        dlt;
    logic [7:0]        sat_rem;
    logic [7:0]        sat_low;
    logic [SAT_QW-1:0] sat_q;
    logic [7:0]        hue_rem;
    logic [HUE_QW-1:0] hue_low;
    logic [HUE_QW-1:0] hue_q;
    logic [7:0]        hue_base;
    logic              hue_neg;
  } hsvc_div_t;

  // one restoring step: returns {quotient bit, new remainder}
  // partial remainder is below a nonzero divisor on entry
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic bit_in,
                                          input logic [7:0] dvs);
    logic [8:0] t;
    logic       q;
    t = {rem, bit_in};
    q = 1'b0;
    if (t >= {1'b0, dvs}) begin
      q = 1'b1;
      t = t - {1'b0, dvs};
    end
    return {q, t[7:0]};
  endfunction

endpackage

`default_nettype wire

### rtl/hsvc_divpipe.sv
`default_nettype none

module hsvc_divpipe (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                en,
  input  wire                in_valid,
  input  hsvc_pkg::hsvc_div_t in_data,
  output logic               out_valid,
  output hsvc_pkg::hsvc_div_t out_data
);
  import hsvc_pkg::*;

  hsvc_div_t              cur [0:DIV_STAGES];
  hsvc_div_t              stage_nxt [0:DIV_STAGES-1];
  hsvc_div_t              stage_r [0:DIV_STAGES-1];
  logic [DIV_STAGES-1:0]  valid_r;

  assign cur[0] = in_data;

  genvar s;
  generate
    for (s = 0; s < DIV_STAGES; s++) begin : g_stage
      assign cur[s+1] = stage_r[s];

      always_comb begin
        hsvc_div_t  t;
        logic [8:0] r;
        t = cur[s];
        r = '0;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
          // saturation: 255*delta / max
          if (s * STEPS_PER_STAGE + k < SAT_QW) begin
            r         = div_step(t.sat_rem, t.sat_low[7], t.mx);
            t.sat_rem = r[7:0];
            t.sat_q   = {t.sat_q[SAT_QW-2:0], r[8]};
            t.sat_low = {t.sat_low[6:0], 1'b0};
          end
          // hue offset: 30*|diff| / delta
          if (s * STEPS_PER_STAGE + k < HUE_QW) begin
            r         = div_step(t.hue_rem, t.hue_low[HUE_QW-1], t.dlt);
            t.hue_rem = r[7:0];
            t.hue_q   = {t.hue_q[HUE_QW-2:0], r[8]};
            t.hue_low = {t.hue_low[HUE_QW-2:0], 1'b0};
          end
        end
        stage_nxt[s] = t;
      end

      always_ff @(posedge clk) begin
        if (en) begin
          stage_r[s] <= stage_nxt[s];
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[DIV_STAGES-2:0], in_valid};
    end
  end

  assign out_valid = valid_r[DIV_STAGES-1];
  assign out_data  = stage_r[DIV_STAGES-1];

endmodule

`default_nettype wire

### rtl/bgr_to_hsv_pixel_convert_unit.sv
`default_nettype none

// channel   direction  handshake            payload
// in_       input      in_valid / in_stall  hsvc_in_t  (blue, green, red)
// out_      output     out_valid / out_stall hsvc_out_t (hue_half, saturation, brightness)
//
// one item accepted per cycle while the output is not stalled; registers in order:
// extremum stage, dividend stage, four divider stages at two quotient bits each,
// result register
// the whole pipe advances together; a stall at the output while a result is held
// freezes every stage and raises in_stall, so nothing is dropped or repeated
// synchronous active-low reset clears the valid bits only

module bgr_to_hsv_pixel_convert_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  hsvc_pkg::hsvc_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output hsvc_pkg::hsvc_out_t out_data
);
  import hsvc_pkg::*;

  // stage a: max, min, winning channel and signed hue difference
  typedef struct packed {
    logic [7:0] mx;
    logic [7:0] dlt;
    logic [7:0] mag;
    logic       neg;
    logic [7:0] base;
  } hsvc_ext_t;

  logic       en;
  logic       a_valid_r;
  hsvc_ext_t  a_r;
  hsvc_ext_t  a_nxt;
  logic       b_valid_r;
  hsvc_div_t  b_r;
  hsvc_div_t  b_nxt;
  logic       d_valid;
  hsvc_div_t  d_data;
  logic       out_valid_r;
  hsvc_out_t  out_r;
  hsvc_out_t  out_nxt;

  // global advance: stop only when a result is held and the sink stalls
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // stage a logic
  always_comb begin
    logic       r_is;
    logic       g_is;
    logic [7:0] mn;
    logic [8:0] df;
    logic [8:0] mg;
    // ties: red over green, green over blue
    r_is = (in_data.red >= in_data.green) && (in_data.red >= in_data.blue);
    g_is = !r_is && (in_data.green >= in_data.blue);
    if (r_is) begin
      a_nxt.mx = in_data.red;
    end else if (g_is) begin
      a_nxt.mx = in_data.green;
    end else begin
      a_nxt.mx = in_data.blue;
    end
    mn = in_data.red;
    if (in_data.green < mn) begin
      mn = in_data.green;
    end
    if (in_data.blue < mn) begin
      mn = in_data.blue;
    end
    a_nxt.dlt = a_nxt.mx - mn;
    if (r_is) begin
      df = {1'b0, in_data.green} - {1'b0, in_data.blue};
    end else if (g_is) begin
      df = {1'b0, in_data.blue} - {1'b0, in_data.red};
    end else begin
      df = {1'b0, in_data.red} - {1'b0, in_data.green};
    end
    a_nxt.neg = df[8];
    mg        = df[8] ? (9'd0 - df) : df;
    a_nxt.mag = mg[7:0];
    // red sector wraps round to 360 degrees when negative
    if (r_is) begin
      a_nxt.base = df[8] ? HUE_HALF_RED_WRAP : HUE_HALF_RED;
    end else if (g_is) begin
      a_nxt.base = HUE_HALF_GREEN;
    end else begin
      a_nxt.base = HUE_HALF_BLUE;
    end
  end

  // stage b logic: dividends 255*delta and 30*|diff| by shift and subtract
  always_comb begin
    logic [15:0] sat_num;
    logic [12:0] hue_num;
    sat_num = {a_r.dlt, 8'd0} - {8'd0, a_r.dlt};
    hue_num = {a_r.mag, 5'd0} - {4'd0, a_r.mag, 1'b0};
    b_nxt.mx       = a_r.mx;
    b_nxt.dlt      = a_r.dlt;
    // upper dividend bits already sit below the divisor when delta is nonzero
    b_nxt.sat_rem  = sat_num[15:8];
    b_nxt.sat_low  = sat_num[7:0];
    b_nxt.sat_q    = '0;
    b_nxt.hue_rem  = hue_num[12:5];
    b_nxt.hue_low  = hue_num[4:0];
    b_nxt.hue_q    = '0;
    b_nxt.hue_base = a_r.base;
    b_nxt.hue_neg  = a_r.neg;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  hsvc_divpipe u_divpipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (b_valid_r),
    .in_data   (b_r),
    .out_valid (d_valid),
    .out_data  (d_data)
  );

  // result: floor of a negative offset takes one more when a remainder is left
  always_comb begin
    logic [7:0] q8;
    logic       rem_nz;
    q8     = {{(8 - HUE_QW){1'b0}}, d_data.hue_q};
    rem_nz = (d_data.hue_rem != 8'd0);
    out_nxt.brightness = d_data.mx;
    if (d_data.dlt == 8'd0) begin
      // grey pixel
      out_nxt.hue_half   = 8'd0;
      out_nxt.saturation = 8'd0;
    end else begin
      out_nxt.saturation = d_data.sat_q;
      if (d_data.hue_neg) begin
        out_nxt.hue_half = d_data.hue_base - q8 - {7'd0, rem_nz};
      end else begin
        out_nxt.hue_half = d_data.hue_base + q8;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_hue_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.hue_half <= HUE_HALF_MAX)
    else $error("hue_half out of range");

  a_black_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.brightness == 8'd0) |->
      (out_r.saturation == 8'd0 && out_r.hue_half == 8'd0))
    else $error("black pixel with nonzero hue or saturation");

  a_grey_hue : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.saturation == 8'd0) |-> out_r.hue_half == 8'd0)
    else $error("zero saturation with nonzero hue");

  a_sat_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.saturation <= 8'd255 && (out_r.brightness != 8'd0 ||
      out_r.saturation == 8'd0))
    else $error("saturation without brightness");
`endif

endmodule

`default_nettype wire
